// File: sv/qte_pkg.sv
// Package: widths, stage map, CORDIC angle table and stage functions for the Euler unit.
package qte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int QW = 16;
  localparam int CW = 35;
  localparam int XW = 38;
  localparam int SQ_STEPS = 32;
  localparam int SQ_BASE = 4;
  localparam int CORD_BASE = SQ_BASE + SQ_STEPS;
  localparam int NS = CORD_BASE + CORDIC_STEPS + 2;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [31:0]          acc;
    logic                 zero;
  } cord_t;

  function automatic logic [31:0] atan_step(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      25: a = 32'd20;
      26: a = 32'd10;
      27: a = 32'd5;
      28: a = 32'd3;
      29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  function automatic cord_t cord_init(input logic signed [XW-1:0] y,
                                      input logic signed [XW-1:0] x);
    cord_t r;
    r.zero = (x == '0) && (y == '0);
    if (x[XW-1]) begin
      r.x   = -x;
      r.y   = -y;
      r.acc = 32'h8000_0000;
    end else begin
      r.x   = x;
      r.y   = y;
      r.acc = 32'h0;
    end
    return r;
  endfunction

  function automatic cord_t cord_step(input cord_t c, input int i);
    cord_t r;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    r = c;
    if (!c.y[XW-1]) begin
      r.x   = c.x + dx;
      r.y   = c.y - dy;
      r.acc = c.acc + atan_step(i);
    end else begin
      r.x   = c.x - dx;
      r.y   = c.y + dy;
      r.acc = c.acc - atan_step(i);
    end
    return r;
  endfunction

  function automatic logic [15:0] cord_angle(input cord_t c);
    logic [31:0] s;
    s = c.acc + 32'h0000_8000;
    return c.zero ? 16'h0 : s[31:16];
  endfunction

endpackage

// File: sv/quaternion_to_euler_angles_unit.sv
// Top level: pipelined quaternion to roll, pitch and yaw conversion.
// Stages from input acceptance to result: products, DCM terms, squares, sum, 32 square-root
// stages, CORDIC set-up, 16 CORDIC stages, output stage.
// Throughput: one item per cycle while the output is not stalled; the square-root and CORDIC stages are fully unrolled.
// A one-item input skid takes an item while a result waits on a stalled output.
// Reset clears all valid bits and the skid; payload registers are not reset.
module quaternion_to_euler_angles_unit
  import qte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // q_scalar, q_x, q_y, q_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle
);

  logic          en;
  logic          sk_v;
  logic [63:0]   sk_data;
  logic          src_v;
  logic [63:0]   src;
  logic [NS-1:0] v;

  logic signed [2*QW-1:0] p_yz, p_sx, p_ss, p_xx, p_yy, p_zz, p_xz, p_sy, p_xy, p_sz;
  logic signed [CW-1:0]   c32 [1:SQ_BASE+SQ_STEPS-1];
  logic signed [CW-1:0]   c33 [1:SQ_BASE+SQ_STEPS-1];
  logic signed [CW-1:0]   c11 [1:SQ_BASE+SQ_STEPS-1];
  logic signed [CW-1:0]   c21 [1:SQ_BASE+SQ_STEPS-1];
  logic signed [CW-1:0]   c31;
  logic signed [CW-1:0]   num [2:SQ_BASE+SQ_STEPS-1];
  logic [63:0]            asq, bsq;
  logic [63:0]            rem  [SQ_BASE-1:SQ_BASE+SQ_STEPS-1];
  logic [63:0]            root [SQ_BASE-1:SQ_BASE+SQ_STEPS-1];
  cord_t                  cr [CORD_BASE:CORD_BASE+CORDIC_STEPS];
  cord_t                  cp [CORD_BASE:CORD_BASE+CORDIC_STEPS];
  cord_t                  cy [CORD_BASE:CORD_BASE+CORDIC_STEPS];
  logic [1:0]             pf [CORD_BASE:CORD_BASE+CORDIC_STEPS];
  logic [15:0]            roll_o, pitch_o, yaw_o;

  logic signed [QW-1:0]   qs, qx, qy, qz;
  logic signed [CW-1:0]   ha, hb;
  logic signed [2*CW-1:0] ha_sq, hb_sq;
  logic signed [15:0]     pang;
  logic [15:0]            pitch_n;

  assign en       = !v[NS-1] || m_tready;
  assign s_tready = !sk_v;
  assign src_v    = sk_v || s_tvalid;
  assign src      = sk_v ? sk_data : s_tdata;
  assign m_tvalid = v[NS-1];
  assign m_tdata  = {yaw_o, pitch_o, roll_o};

  assign qs = src[QW-1:0];
  assign qx = src[16+QW-1:16];
  assign qy = src[32+QW-1:32];
  assign qz = src[48+QW-1:48];

  assign ha    = c32[1] >>> 1;
  assign hb    = c33[1] >>> 1;
  assign ha_sq = ha * ha;
  assign hb_sq = hb * hb;

  always_comb begin
    pang = cord_angle(cp[CORD_BASE+CORDIC_STEPS]);
    if (pf[CORD_BASE+CORDIC_STEPS][1]) begin
      if (cp[CORD_BASE+CORDIC_STEPS].zero) begin
        pitch_n = 16'sd0;
      end else if (pf[CORD_BASE+CORDIC_STEPS][0]) begin
        pitch_n = -16'sd16384;
      end else begin
        pitch_n = 16'sd16384;
      end
    end else if (pang > 16'sd16384) begin
      pitch_n = 16'sd16384;
    end else if (pang < -16'sd16384) begin
      pitch_n = -16'sd16384;
    end else begin
      pitch_n = pang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      sk_v <= 1'b0;
    end else begin
      if (en) begin
        v    <= {v[NS-2:0], src_v};
        sk_v <= 1'b0;
      end else if (s_tvalid && !sk_v) begin
        sk_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!en && s_tvalid && !sk_v) begin
      sk_data <= s_tdata;
    end
    if (en) begin
      p_yz <= qy * qz;
      p_sx <= qs * qx;
      p_ss <= qs * qs;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_xz <= qx * qz;
      p_sy <= qs * qy;
      p_xy <= qx * qy;
      p_sz <= qs * qz;

      c32[1] <= (CW'(p_yz) + CW'(p_sx)) <<< 1;
      c33[1] <= CW'(p_ss) - CW'(p_xx) - CW'(p_yy) + CW'(p_zz);
      c31    <= (CW'(p_xz) - CW'(p_sy)) <<< 1;
      c11[1] <= CW'(p_ss) + CW'(p_xx) - CW'(p_yy) - CW'(p_zz);
      c21[1] <= (CW'(p_xy) + CW'(p_sz)) <<< 1;

      asq    <= ha_sq[63:0];
      bsq    <= hb_sq[63:0];
      num[2] <= (-c31) >>> 1;

      for (int k = 2; k < SQ_BASE + SQ_STEPS; k++) begin
        c32[k] <= c32[k-1];
        c33[k] <= c33[k-1];
        c11[k] <= c11[k-1];
        c21[k] <= c21[k-1];
      end
      for (int k = 3; k < SQ_BASE + SQ_STEPS; k++) begin
        num[k] <= num[k-1];
      end

      rem[SQ_BASE-1]  <= asq + bsq;
      root[SQ_BASE-1] <= '0;
      for (int j = 0; j < SQ_STEPS; j++) begin
        if (rem[SQ_BASE-1+j] >= root[SQ_BASE-1+j] + (64'd1 << (62 - 2 * j))) begin
          rem[SQ_BASE+j]  <= rem[SQ_BASE-1+j] - (root[SQ_BASE-1+j] + (64'd1 << (62 - 2 * j)));
          root[SQ_BASE+j] <= (root[SQ_BASE-1+j] >> 1) + (64'd1 << (62 - 2 * j));
        end else begin
          rem[SQ_BASE+j]  <= rem[SQ_BASE-1+j];
          root[SQ_BASE+j] <= root[SQ_BASE-1+j] >> 1;
        end
      end

      cr[CORD_BASE] <= cord_init(XW'(c32[CORD_BASE-1]), XW'(c33[CORD_BASE-1]));
      cy[CORD_BASE] <= cord_init(XW'(c21[CORD_BASE-1]), XW'(c11[CORD_BASE-1]));
      cp[CORD_BASE] <= cord_init(XW'(num[CORD_BASE-1]),
                                 $signed({{(XW-33){1'b0}}, root[CORD_BASE-1][32:0]}));
      pf[CORD_BASE] <= {root[CORD_BASE-1] == '0, num[CORD_BASE-1][CW-1]};

      for (int i = 0; i < CORDIC_STEPS; i++) begin
        cr[CORD_BASE+1+i] <= cord_step(cr[CORD_BASE+i], i);
        cy[CORD_BASE+1+i] <= cord_step(cy[CORD_BASE+i], i);
        cp[CORD_BASE+1+i] <= cord_step(cp[CORD_BASE+i], i);
        pf[CORD_BASE+1+i] <= pf[CORD_BASE+i];
      end

      roll_o  <= cord_angle(cr[CORD_BASE+CORDIC_STEPS]);
      yaw_o   <= cord_angle(cy[CORD_BASE+CORDIC_STEPS]);
      pitch_o <= pitch_n;
    end
  end

endmodule

// File: sv/qte_checker.sv
// Checker: port-level assertions for the Euler unit, bound to the top level.
module qte_checker
  import qte_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed under stall");

  a_pitch: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd16384) &&
                 ($signed(m_tdata[31:16]) >= -16'sd16384))
    else $error("pitch outside quarter turn");

  a_skid: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && m_tvalid && !m_tready |=> !s_tready)
    else $error("skid not taken while output stalled");

  a_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !m_tvalid)
    else $error("result shown straight after reset");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    !s_tready && (!m_tvalid || m_tready) |=> s_tready)
    else $error("skid not drained when pipeline advanced");

endmodule

bind quaternion_to_euler_angles_unit qte_checker u_qte_checker (.*);
